>>> src/lrk_pkg.sv
// Package for the Lorenz RK4 step unit: shared constants, register codes and types.
// No dependencies; every other file of the block but lrk_delay imports it.
`timescale 1ns / 1ps

package lrk_pkg;

   // Default number format: signed Q24.24 in 48 bits.
   localparam int WORD_BITS_DEF = 48;
   localparam int FRAC_BITS_DEF = 24;

   // Configuration register widths and reset values.
   localparam int PARAM_REG_W = 41;
   localparam int TS_REG_W    = 25;
   localparam logic [PARAM_REG_W-1:0] SIGMA_RESET = 41'd167772160;
   localparam logic [PARAM_REG_W-1:0] RHO_RESET   = 41'd469762048;
   localparam logic [PARAM_REG_W-1:0] BETA_RESET  = 41'd44739243;
   localparam logic [TS_REG_W-1:0]    TS_RESET    = 25'd16777;

   // The h/6 weight is round(h/6) = floor((h + 3) / 6), done by a reciprocal multiply.
   localparam int H6_SHIFT = 32;
   localparam logic [29:0] H6_RECIP = 30'd715827883;
   localparam logic [TS_REG_W-1:0] H6_RESET = TS_REG_W'((int'(TS_RESET) + 3) / 6);

   // Configuration port geometry.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Pipeline depth of one rounded multiplier.
   localparam int MUL_LAT = 4;

   // Register index codes.
   typedef enum logic [1:0] {
      REG_SIGMA     = 2'd0,
      REG_RHO       = 2'd1,
      REG_BETA      = 2'd2,
      REG_TIME_STEP = 2'd3
   } lrk_reg_type;

   // Control bits that travel with every item through the pipeline.
   typedef struct packed {
      logic valid;
      logic ovf;
   } lrk_tag_type;

endpackage

>>> src/lrk_delay.sv
// Payload delay line with a shared advance enable.
// Depends on nothing; used to align operands across the pipeline.
`timescale 1ns / 1ps

module lrk_delay #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // Shift the whole line whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

>>> src/lrk_mul.sv
// Pipelined signed fixed-point multiplier with round-half-away and saturation.
// Depends on lrk_pkg for the item tag type.
`timescale 1ns / 1ps

module lrk_mul
   import lrk_pkg::*;
#(
   parameter int W     = 48,
   parameter int SHIFT = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  lrk_tag_type up_tag,
   output logic [W-1:0] p,
   output lrk_tag_type dn_tag
);

   localparam int H  = (W + 1) / 2;
   localparam int L  = W - H;
   localparam int PW = 2 * W + 1;
   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]     ua_ff, ub_ff;
   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [2*H-1:0]   p00_ff;
   logic [H+L-1:0]   p01_ff, p10_ff;
   logic [2*L-1:0]   p11_ff;
   logic [2*W-1:0]   prod_ff;
   logic [W-1:0]     p_ff;
   lrk_tag_type      tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   logic [W-1:0]     ua_in, ub_in;
   logic [2*W-1:0]   prod_in;
   logic [PW-1:0]    rnd, quo, lim;
   logic             sat;
   logic [W-1:0]     p_in;

   // Magnitudes of the operands.
   always_comb begin
      ua_in = a[W-1] ? (~a + W'(1)) : a;
      ub_in = b[W-1] ? (~b + W'(1)) : b;
   end

   // Sum of the four partial products.
   always_comb begin
      prod_in = (2*W)'(p00_ff)
              + ((2*W)'(p01_ff) << H)
              + ((2*W)'(p10_ff) << H)
              + ((2*W)'(p11_ff) << (2 * H));
   end

   // Round, scale, saturate and restore the sign.
   always_comb begin
      rnd = PW'(prod_ff) + (PW'(1) << (SHIFT - 1));
      quo = rnd >> SHIFT;
      lim = PW'(WMAX) + PW'(neg3_ff);
      sat = quo > lim;
      if (sat) begin
         p_in = neg3_ff ? WMIN : WMAX;
      end else if (neg3_ff) begin
         p_in = ~quo[W-1:0] + W'(1);
      end else begin
         p_in = quo[W-1:0];
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg1_ff <= a[W-1] ^ b[W-1];
         p00_ff  <= (2*H)'(ua_ff[H-1:0]) * (2*H)'(ub_ff[H-1:0]);
         p01_ff  <= (H+L)'(ua_ff[H-1:0]) * (H+L)'(ub_ff[W-1:H]);
         p10_ff  <= (H+L)'(ua_ff[W-1:H]) * (H+L)'(ub_ff[H-1:0]);
         p11_ff  <= (2*L)'(ua_ff[W-1:H]) * (2*L)'(ub_ff[W-1:H]);
         neg2_ff <= neg1_ff;
         prod_ff <= prod_in;
         neg3_ff <= neg2_ff;
         p_ff    <= p_in;
      end
   end

   // Item tags travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (en) begin
         tag1_ff <= up_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= '{valid: tag3_ff.valid, ovf: tag3_ff.ovf | sat};
      end
   end

   assign p      = p_ff;
   assign dn_tag = tag4_ff;

endmodule

>>> src/lrk_deriv.sv
// Lorenz derivative unit: (sigma*(y-x), x*(rho-z)-y, x*y-beta*z), saturating.
// Depends on lrk_pkg, lrk_mul and lrk_delay.
`timescale 1ns / 1ps

module lrk_deriv
   import lrk_pkg::*;
#(
   parameter int W  = 48,
   parameter int FB = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [W-1:0]      sigma,
   input  logic [W-1:0]      rho,
   input  logic [W-1:0]      beta,
   input  logic [2:0][W-1:0] st,
   input  lrk_tag_type       up_tag,
   output logic [2:0][W-1:0] kv,
   output lrk_tag_type       dn_tag
);

   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // Returns {overflow, a - b saturated}.
   function automatic logic [W:0] sat_sub(logic [W-1:0] x, logic [W-1:0] y);
      logic [W:0] d;
      d = {x[W-1], x} - {y[W-1], y};
      if (d[W] != d[W-1]) begin
         return {1'b1, d[W] ? WMIN : WMAX};
      end
      return {1'b0, d[W-1:0]};
   endfunction

   logic [W:0]   yx, rz, dy, dz;
   logic [W-1:0] yx_ff, rz_ff, x_ff, y_ff, z_ff, y_dly;
   logic [3:0][W-1:0] prod;
   lrk_tag_type  tag1_ff, tag_ff;
   lrk_tag_type  mtag [4];
   lrk_tag_type  side_tag;
   logic [2:0][W-1:0] kv_ff;

   // Front differences.
   always_comb begin
      yx = sat_sub(st[1], st[0]);
      rz = sat_sub(rho, st[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yx_ff <= yx[W-1:0];
         rz_ff <= rz[W-1:0];
         x_ff  <= st[0];
         y_ff  <= st[1];
         z_ff  <= st[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else if (en) begin
         tag1_ff <= '{valid: up_tag.valid, ovf: up_tag.ovf | yx[W] | rz[W]};
      end
   end

   // The four products run side by side; only the first carries the item tag.
   assign side_tag = '{valid: tag1_ff.valid, ovf: 1'b0};

   lrk_mul #(.W(W), .SHIFT(FB)) u_mul_sig (
      .clock, .reset, .en, .a(sigma), .b(yx_ff), .up_tag(tag1_ff),
      .p(prod[0]), .dn_tag(mtag[0])
   );
   lrk_mul #(.W(W), .SHIFT(FB)) u_mul_rho (
      .clock, .reset, .en, .a(x_ff), .b(rz_ff), .up_tag(side_tag),
      .p(prod[1]), .dn_tag(mtag[1])
   );
   lrk_mul #(.W(W), .SHIFT(FB)) u_mul_xy (
      .clock, .reset, .en, .a(x_ff), .b(y_ff), .up_tag(side_tag),
      .p(prod[2]), .dn_tag(mtag[2])
   );
   lrk_mul #(.W(W), .SHIFT(FB)) u_mul_beta (
      .clock, .reset, .en, .a(beta), .b(z_ff), .up_tag(side_tag),
      .p(prod[3]), .dn_tag(mtag[3])
   );

   // y waits for the products.
   lrk_delay #(.WIDTH(W), .DEPTH(MUL_LAT)) u_y_dly (
      .clock, .en, .din(y_ff), .dout(y_dly)
   );

   // Back differences.
   always_comb begin
      dy = sat_sub(prod[1], y_dly);
      dz = sat_sub(prod[2], prod[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kv_ff[0] <= prod[0];
         kv_ff[1] <= dy[W-1:0];
         kv_ff[2] <= dz[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= '{valid: mtag[0].valid,
                     ovf: mtag[0].ovf | mtag[1].ovf | mtag[2].ovf | mtag[3].ovf
                          | dy[W] | dz[W]};
      end
   end

   assign kv     = kv_ff;
   assign dn_tag = tag_ff;

endmodule

>>> src/lrk_step.sv
// Intermediate state unit: t = s + round(h*k / 2^SHIFT), saturating, per lane.
// Depends on lrk_pkg, lrk_mul and lrk_delay.
`timescale 1ns / 1ps

module lrk_step
   import lrk_pkg::*;
#(
   parameter int W     = 48,
   parameter int SHIFT = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [W-1:0]      h,
   input  logic [2:0][W-1:0] st,
   input  logic [2:0][W-1:0] kv,
   input  lrk_tag_type       up_tag,
   output logic [2:0][W-1:0] nxt,
   output lrk_tag_type       dn_tag
);

   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // Returns {overflow, a + b saturated}.
   function automatic logic [W:0] sat_add(logic [W-1:0] x, logic [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} + {y[W-1], y};
      if (s[W] != s[W-1]) begin
         return {1'b1, s[W] ? WMIN : WMAX};
      end
      return {1'b0, s[W-1:0]};
   endfunction

   logic [2:0][W-1:0] prod, st_dly, nxt_ff;
   logic [2:0][W:0]   sum;
   lrk_tag_type       mtag [3];
   lrk_tag_type       side_tag, tag_ff;

   assign side_tag = '{valid: up_tag.valid, ovf: 1'b0};

   // One scaled product per lane; lane zero carries the tag.
   for (genvar i = 0; i < 3; i++) begin : g_lane
      lrk_mul #(.W(W), .SHIFT(SHIFT)) u_mul (
         .clock, .reset, .en, .a(h), .b(kv[i]),
         .up_tag((i == 0) ? up_tag : side_tag),
         .p(prod[i]), .dn_tag(mtag[i])
      );
   end

   lrk_delay #(.WIDTH(3 * W), .DEPTH(MUL_LAT)) u_s_dly (
      .clock, .en, .din(st), .dout(st_dly)
   );

   // Add the increment to the base state.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = sat_add(st_dly[i], prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            nxt_ff[i] <= sum[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= '{valid: mtag[0].valid,
                     ovf: mtag[0].ovf | mtag[1].ovf | mtag[2].ovf
                          | sum[0][W] | sum[1][W] | sum[2][W]};
      end
   end

   assign nxt    = nxt_ff;
   assign dn_tag = tag_ff;

endmodule

>>> src/lrk_comb.sv
// Final combine: s + round(h6 * (k1 + 2k2 + 2k3 + k4)), one saturating add per stage.
// Depends on lrk_pkg, lrk_mul and lrk_delay.
`timescale 1ns / 1ps

module lrk_comb
   import lrk_pkg::*;
#(
   parameter int W  = 48,
   parameter int FB = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [W-1:0]      h6,
   input  logic [2:0][W-1:0] st,
   input  logic [2:0][W-1:0] k1,
   input  logic [2:0][W-1:0] k2,
   input  logic [2:0][W-1:0] k3,
   input  logic [2:0][W-1:0] k4,
   input  lrk_tag_type       up_tag,
   output logic [2:0][W-1:0] res,
   output lrk_tag_type       dn_tag
);

   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // Returns {overflow, a + b saturated}.
   function automatic logic [W:0] sat_add(logic [W-1:0] x, logic [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} + {y[W-1], y};
      if (s[W] != s[W-1]) begin
         return {1'b1, s[W] ? WMIN : WMAX};
      end
      return {1'b0, s[W-1:0]};
   endfunction

   logic [2:0][W-1:0] k1a_ff, d2_ff, d3a_ff, k4a_ff;
   logic [2:0][W-1:0] a1_ff, d3b_ff, k4b_ff;
   logic [2:0][W-1:0] a2_ff, k4c_ff;
   logic [2:0][W-1:0] a3_ff;
   logic [2:0][W-1:0] prod, st_dly, res_ff;
   logic [2:0][W:0]   d2, d3, a1, a2, a3, fin;
   lrk_tag_type       c1_ff, c2_ff, c3_ff, c4_ff, tag_ff, side_tag;
   lrk_tag_type       mtag [3];

   // Weighted sum, one dependent add per stage.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d2[i] = sat_add(k2[i], k2[i]);
         d3[i] = sat_add(k3[i], k3[i]);
         a1[i] = sat_add(k1a_ff[i], d2_ff[i]);
         a2[i] = sat_add(a1_ff[i], d3b_ff[i]);
         a3[i] = sat_add(a2_ff[i], k4c_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            k1a_ff[i] <= k1[i];
            d2_ff[i]  <= d2[i][W-1:0];
            d3a_ff[i] <= d3[i][W-1:0];
            k4a_ff[i] <= k4[i];
            a1_ff[i]  <= a1[i][W-1:0];
            d3b_ff[i] <= d3a_ff[i];
            k4b_ff[i] <= k4a_ff[i];
            a2_ff[i]  <= a2[i][W-1:0];
            k4c_ff[i] <= k4b_ff[i];
            a3_ff[i]  <= a3[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
      end else if (en) begin
         c1_ff <= '{valid: up_tag.valid, ovf: up_tag.ovf | d2[0][W] | d2[1][W] | d2[2][W]
                    | d3[0][W] | d3[1][W] | d3[2][W]};
         c2_ff <= '{valid: c1_ff.valid, ovf: c1_ff.ovf | a1[0][W] | a1[1][W] | a1[2][W]};
         c3_ff <= '{valid: c2_ff.valid, ovf: c2_ff.ovf | a2[0][W] | a2[1][W] | a2[2][W]};
         c4_ff <= '{valid: c3_ff.valid, ovf: c3_ff.ovf | a3[0][W] | a3[1][W] | a3[2][W]};
      end
   end

   // Scale by h/6.
   assign side_tag = '{valid: c4_ff.valid, ovf: 1'b0};

   for (genvar i = 0; i < 3; i++) begin : g_lane
      lrk_mul #(.W(W), .SHIFT(FB)) u_mul (
         .clock, .reset, .en, .a(h6), .b(a3_ff[i]),
         .up_tag((i == 0) ? c4_ff : side_tag),
         .p(prod[i]), .dn_tag(mtag[i])
      );
   end

   lrk_delay #(.WIDTH(3 * W), .DEPTH(MUL_LAT + 4)) u_s_dly (
      .clock, .en, .din(st), .dout(st_dly)
   );

   // Add the step to the starting state.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin[i] = sat_add(st_dly[i], prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= fin[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= '{valid: mtag[0].valid,
                     ovf: mtag[0].ovf | mtag[1].ovf | mtag[2].ovf
                          | fin[0][W] | fin[1][W] | fin[2][W]};
      end
   end

   assign res    = res_ff;
   assign dn_tag = tag_ff;

endmodule

>>> src/lorenz_rk4_step_unit.sv
// Top level of the Lorenz RK4 step unit: CSR block, four derivative passes, output skid.
// Depends on lrk_pkg, lrk_delay, lrk_mul, lrk_deriv, lrk_step and lrk_comb.
`timescale 1ns / 1ps

// This unit advances one particle state (x, y, z) by one classical fourth-order
// Runge-Kutta step of the Lorenz equations in signed fixed point, saturating any
// value that overflows and flagging it in rsp_tuser. It takes one item per clock
// while the skid entry is empty and returns results in order; an item passes
// through the four derivative passes, three intermediate-state passes and the
// final combine in series, each built around four-stage multipliers.
// An output register with a skid entry lets a new item in while a
// result waits. Write sigma, rho, beta and time_step over the CSR port only
// while no items are in flight.
module lorenz_rk4_step_unit
   import lrk_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: x_in, y_in, z_in
   input  logic [((3*WORD_BITS+7)/8)*8-1:0] req_tdata,
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: x_out, y_out, z_out
   output logic [((3*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: overflow
   output logic                  rsp_tuser,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int W         = WORD_BITS;
   localparam int DATA_W    = ((3 * W + 7) / 8) * 8;
   localparam int CW        = (W > PARAM_REG_W) ? W : PARAM_REG_W;
   localparam int DERIV_LAT = MUL_LAT + 2;
   localparam int STEP_LAT  = MUL_LAT + 1;
   localparam int ROUND_LAT = DERIV_LAT + STEP_LAT;
   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

   // Parameter words larger than the largest positive word are clamped.
   function automatic logic [W-1:0] clamp_word(logic [PARAM_REG_W-1:0] v);
      logic [CW-1:0] e;
      e = CW'(v);
      if (e > CW'(WMAX)) begin
         return WMAX;
      end
      return e[W-1:0];
   endfunction

   logic [PARAM_REG_W-1:0] sigma_ff, rho_ff, beta_ff;
   logic [TS_REG_W-1:0]    time_step_ff, h6_ff, h6_in;
   logic [TS_REG_W:0]      ts_bias;
   logic [TS_REG_W+30:0]   h6_prod;
   lrk_reg_type            csr_idx;
   logic                   csr_wr;
   logic [W-1:0]           sigma_w, rho_w, beta_w, h_w, h6_w;

   // Register file.
   assign csr_idx    = lrk_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff     <= SIGMA_RESET;
         rho_ff       <= RHO_RESET;
         beta_ff      <= BETA_RESET;
         time_step_ff <= TS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SIGMA:     sigma_ff     <= csr_pwdata[PARAM_REG_W-1:0];
            REG_RHO:       rho_ff       <= csr_pwdata[PARAM_REG_W-1:0];
            REG_BETA:      beta_ff      <= csr_pwdata[PARAM_REG_W-1:0];
            REG_TIME_STEP: time_step_ff <= csr_pwdata[TS_REG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SIGMA:     csr_prdata = CSR_DATA_W'(sigma_ff);
         REG_RHO:       csr_prdata = CSR_DATA_W'(rho_ff);
         REG_BETA:      csr_prdata = CSR_DATA_W'(beta_ff);
         REG_TIME_STEP: csr_prdata = CSR_DATA_W'(time_step_ff);
      endcase
   end

   // The h/6 weight, refreshed every cycle from the step register.
   always_comb begin
      ts_bias = (TS_REG_W+1)'(time_step_ff) + (TS_REG_W+1)'(3);
      h6_prod = (TS_REG_W+31)'(ts_bias) * (TS_REG_W+31)'(H6_RECIP);
      h6_in   = h6_prod[H6_SHIFT +: TS_REG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h6_ff <= H6_RESET;
      end else begin
         h6_ff <= h6_in;
      end
   end

   always_comb begin
      sigma_w = clamp_word(sigma_ff);
      rho_w   = clamp_word(rho_ff);
      beta_w  = clamp_word(beta_ff);
      h_w     = clamp_word(PARAM_REG_W'(time_step_ff));
      h6_w    = clamp_word(PARAM_REG_W'(h6_ff));
   end

   // Pipeline advance and item entry.
   logic              en;
   logic              skid_valid_ff, main_valid_ff;
   logic              skid_valid_in, main_valid_in;
   logic [3*W:0]      skid_data_ff, main_data_ff, skid_data_in, main_data_in;
   lrk_tag_type       tag0;
   logic [2:0][W-1:0] s0, s6, s17, s28, s39;
   logic [2:0][W-1:0] k1, k2, k3, k4, k1d, k2d, k3d, t2, t3, t4, res;
   lrk_tag_type       tk1, tk2, tk3, tk4, tt2, tt3, tt4, tres;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign tag0       = '{valid: req_tvalid, ovf: 1'b0};
   assign s0[0]      = req_tdata[W-1:0];
   assign s0[1]      = req_tdata[2*W-1:W];
   assign s0[2]      = req_tdata[3*W-1:2*W];

   // Base state copies for each pass.
   lrk_delay #(.WIDTH(3 * W), .DEPTH(DERIV_LAT)) u_s_a (
      .clock, .en, .din(s0), .dout(s6)
   );
   lrk_delay #(.WIDTH(3 * W), .DEPTH(ROUND_LAT)) u_s_b (
      .clock, .en, .din(s6), .dout(s17)
   );
   lrk_delay #(.WIDTH(3 * W), .DEPTH(ROUND_LAT)) u_s_c (
      .clock, .en, .din(s17), .dout(s28)
   );
   lrk_delay #(.WIDTH(3 * W), .DEPTH(ROUND_LAT)) u_s_d (
      .clock, .en, .din(s28), .dout(s39)
   );

   // First derivative and the half step along it.
   lrk_deriv #(.W(W), .FB(FRAC_BITS)) u_deriv1 (
      .clock, .reset, .en, .sigma(sigma_w), .rho(rho_w), .beta(beta_w),
      .st(s0), .up_tag(tag0), .kv(k1), .dn_tag(tk1)
   );
   lrk_step #(.W(W), .SHIFT(FRAC_BITS + 1)) u_step1 (
      .clock, .reset, .en, .h(h_w), .st(s6), .kv(k1), .up_tag(tk1),
      .nxt(t2), .dn_tag(tt2)
   );

   // Second derivative and the half step along it.
   lrk_deriv #(.W(W), .FB(FRAC_BITS)) u_deriv2 (
      .clock, .reset, .en, .sigma(sigma_w), .rho(rho_w), .beta(beta_w),
      .st(t2), .up_tag(tt2), .kv(k2), .dn_tag(tk2)
   );
   lrk_step #(.W(W), .SHIFT(FRAC_BITS + 1)) u_step2 (
      .clock, .reset, .en, .h(h_w), .st(s17), .kv(k2), .up_tag(tk2),
      .nxt(t3), .dn_tag(tt3)
   );

   // Third derivative and the full step along it.
   lrk_deriv #(.W(W), .FB(FRAC_BITS)) u_deriv3 (
      .clock, .reset, .en, .sigma(sigma_w), .rho(rho_w), .beta(beta_w),
      .st(t3), .up_tag(tt3), .kv(k3), .dn_tag(tk3)
   );
   lrk_step #(.W(W), .SHIFT(FRAC_BITS)) u_step3 (
      .clock, .reset, .en, .h(h_w), .st(s28), .kv(k3), .up_tag(tk3),
      .nxt(t4), .dn_tag(tt4)
   );

   // Fourth derivative.
   lrk_deriv #(.W(W), .FB(FRAC_BITS)) u_deriv4 (
      .clock, .reset, .en, .sigma(sigma_w), .rho(rho_w), .beta(beta_w),
      .st(t4), .up_tag(tt4), .kv(k4), .dn_tag(tk4)
   );

   // Earlier slopes wait for the last one.
   lrk_delay #(.WIDTH(3 * W), .DEPTH(3 * ROUND_LAT)) u_k1_dly (
      .clock, .en, .din(k1), .dout(k1d)
   );
   lrk_delay #(.WIDTH(3 * W), .DEPTH(2 * ROUND_LAT)) u_k2_dly (
      .clock, .en, .din(k2), .dout(k2d)
   );
   lrk_delay #(.WIDTH(3 * W), .DEPTH(ROUND_LAT)) u_k3_dly (
      .clock, .en, .din(k3), .dout(k3d)
   );

   lrk_comb #(.W(W), .FB(FRAC_BITS)) u_comb (
      .clock, .reset, .en, .h6(h6_w), .st(s39), .k1(k1d), .k2(k2d), .k3(k3d),
      .k4(k4), .up_tag(tk4), .res(res), .dn_tag(tres)
   );

   // Output register with one skid entry.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (tres.valid) begin
         if (!main_valid_ff || rsp_tready) begin
            main_valid_in = 1'b1;
            main_data_in  = {tres.ovf, res[2], res[1], res[0]};
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = {tres.ovf, res[2], res[1], res[0]};
         end
      end else if (rsp_tready) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = DATA_W'(main_data_ff[3*W-1:0]);
   assign rsp_tuser  = main_data_ff[3*W];

endmodule
